// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the design. They compile to nothing when SYNTH
// is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_SAME(label, clock, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clock, rst_n, ante, cons, msg)

`endif

`endif

// File: design/bmm_pkg.sv
// ---------------------------------------------------------------------------
// Banked memory map package
// Operation codes, map addresses and default sizes for the banked memory map.
// ---------------------------------------------------------------------------
package bmm_pkg;

	typedef enum logic [2:0] {
		OP_RD_BYTE = 3'd0,
		OP_RD_WORD = 3'd1,
		OP_WR_BYTE = 3'd2,
		OP_WR_WORD = 3'd3,
		OP_LD_BOOT = 3'd4,
		OP_LD_CART = 3'd5,
		OP_UNMAP   = 3'd6
	} op_t;

	localparam int ROM_BANKS_DEF  = 32;
	localparam int DMA_LENGTH_DEF = 160;
	localparam int BOOT_SIZE      = 256;
	localparam int BANK_BYTES     = 16384;
	localparam int RAM_DEPTH      = 32768;

	localparam logic [15:0] JOYPAD_ADDR = 16'hFF00;
	localparam logic [15:0] DIV_ADDR    = 16'hFF04;
	localparam logic [15:0] LY_ADDR     = 16'hFF44;
	localparam logic [15:0] DMA_ADDR    = 16'hFF46;
	localparam logic [15:0] LAST_ADDR   = 16'hFFFF;

	// Work RAM indexes (address minus 0x8000) with a non-zero reset value.
	localparam logic [14:0] JOYPAD_IDX  = 15'h7F00;
	localparam logic [14:0] JOYNEXT_IDX = 15'h7F01;
	localparam logic [14:0] LCDC_IDX    = 15'h7F40;
	localparam logic [6:0]  OAM_PAGE    = 7'h7E;

	localparam logic [7:0] JOYPAD_KEEP = 8'hCF;
	localparam logic [7:0] JOYPAD_INIT = 8'hFF;
	localparam logic [7:0] LCDC_INIT   = 8'h91;
	localparam logic [4:0] BANK_MASK_W = 5'h1F;

endpackage

// File: design/banked_memory_map_with_sprite_dma.sv
// ---------------------------------------------------------------------------
// Banked memory map with sprite DMA
// Byte and word accesses to a 64K map of boot ROM, banked cartridge ROM and
// work RAM, with a sequenced sprite DMA copy into the 0xFE00 page.
// ---------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | operation, address, write_data, cart_offset
//  out     | out_valid / out_stall| read_data
//
// After reset a clearing pass writes the work RAM reset image (and zeroes the
// boot ROM); in_stall stays high throughout it. A read goes through ST_EXEC,
// ST_RD0 and ST_DONE; a word read adds ST_RD1. A joypad byte write and a work
// RAM word write below 0xFFFF add ST_JOY or ST_WHI; every other write, the
// loads, unmap and the spare code go from ST_EXEC straight to ST_DONE. A DMA
// byte write reads each byte from the map in ST_DMA_RD and writes it through
// the work RAM port in ST_DMA_WR. in_stall drops as the result moves into
// read_data_q, so the next request can be taken from then on.
// Every request gives exactly one result; the block accepts the next request
// while that result still sits in the output register under out_stall.
`include "assert_macros.svh"

module banked_memory_map_with_sprite_dma #(
	parameter int ROM_BANKS  = bmm_pkg::ROM_BANKS_DEF,
	parameter int DMA_LENGTH = bmm_pkg::DMA_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [15:0] address,
	input  logic [15:0] write_data,
	input  logic [18:0] cart_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] read_data
);

	localparam int CART_DEPTH = ROM_BANKS * bmm_pkg::BANK_BYTES;
	localparam int CART_AW    = $clog2(CART_DEPTH);
	localparam int CNT_W      = (DMA_LENGTH > 1) ? $clog2(DMA_LENGTH) : 1;
	localparam logic [CNT_W-1:0] DMA_LAST = CNT_W'(DMA_LENGTH - 1);

	// The selected bank register is five bits wide; the shown bank is the
	// register value modulo ROM_BANKS, precomputed here as a small table.
	typedef logic [31:0][4:0] bank_map_t;

	function automatic bank_map_t build_bank_map();
		bank_map_t m;
		for (int i = 0; i < 32; i++) begin
			m[i] = 5'(i % ROM_BANKS);
		end
		return m;
	endfunction

	localparam bank_map_t BANK_MAP = build_bank_map();

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RD0,
		ST_RD1,
		ST_JOY,
		ST_WHI,
		ST_DMA_RD,
		ST_DMA_WR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SRC_BOOT,
		SRC_CART,
		SRC_RAM
	} src_t;

	state_t           state_q;
	bmm_pkg::op_t     op_q;
	logic [15:0]      addr_q;
	logic [15:0]      data_q;
	logic [18:0]      coff_q;
	logic [15:0]      result_q;
	logic [15:0]      read_data_q;
	logic             out_valid_q;
	logic [4:0]       bank_q;
	logic             boot_mapped_q;
	logic [CNT_W-1:0] dma_cnt_q;
	logic [14:0]      clr_q;

	// Storage.
	logic [7:0] work_ram [bmm_pkg::RAM_DEPTH];
	logic [7:0] boot_rom [bmm_pkg::BOOT_SIZE];
	logic [7:0] cart_rom [CART_DEPTH];

	logic [7:0] ram_rd_q;
	logic [7:0] boot_rd_q;
	logic [7:0] cart_rd_q;
	src_t       src_q;

	// Shared address incrementer, used for the second byte of word requests.
	logic [15:0] addr_inc;
	assign addr_inc = addr_q + 16'd1;

	logic zero_data;
	assign zero_data = (addr_q == bmm_pkg::LY_ADDR) || (addr_q == bmm_pkg::DIV_ADDR);

	// A finished request moves into the output register once that is free.
	logic result_load;
	assign result_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// ---------------------------------------------------------------------
	// Read map: one CPU address is looked up in every cycle, the source is
	// decided here and the byte is picked in the cycle after.
	// ---------------------------------------------------------------------
	logic [15:0]        rd_addr;
	src_t               src_d;
	logic [4:0]         bank_eff;
	logic [CART_AW-1:0] cart_ra;
	logic [7:0]         map_byte;

	always_comb begin
		case (state_q)
			ST_RD0:    rd_addr = addr_inc;
			ST_DMA_RD: rd_addr = {data_q[7:0], 8'(dma_cnt_q)};
			default:   rd_addr = addr_q;
		endcase
	end

	always_comb begin
		if (boot_mapped_q && (rd_addr[15:8] == 8'h00)) begin
			src_d = SRC_BOOT;
		end else if (!rd_addr[15]) begin
			src_d = SRC_CART;
		end else begin
			src_d = SRC_RAM;
		end
		bank_eff = rd_addr[14] ? BANK_MAP[bank_q] : 5'd0;
		cart_ra  = CART_AW'({bank_eff, rd_addr[13:0]});
	end

	always_comb begin
		case (src_q)
			SRC_BOOT: map_byte = boot_rd_q;
			SRC_CART: map_byte = cart_rd_q;
			default:  map_byte = ram_rd_q;
		endcase
	end

	// ---------------------------------------------------------------------
	// Write ports. Each store has one write per cycle, chosen by the state.
	// ---------------------------------------------------------------------
	logic               ram_we;
	logic [14:0]        ram_wa;
	logic [7:0]         ram_wd;
	logic               boot_we;
	logic [7:0]         boot_wa;
	logic [7:0]         boot_wd;
	logic               cart_we;
	logic [CART_AW-1:0] cart_wa;

	always_comb begin
		ram_we  = 1'b0;
		ram_wa  = addr_q[14:0];
		ram_wd  = zero_data ? 8'h00 : data_q[7:0];
		boot_we = 1'b0;
		boot_wa = addr_q[7:0];
		boot_wd = data_q[7:0];
		cart_we = 1'b0;
		cart_wa = coff_q[CART_AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				ram_we  = 1'b1;
				ram_wa  = clr_q;
				if ((clr_q == bmm_pkg::JOYPAD_IDX) || (clr_q == bmm_pkg::JOYNEXT_IDX)) begin
					ram_wd = bmm_pkg::JOYPAD_INIT;
				end else if (clr_q == bmm_pkg::LCDC_IDX) begin
					ram_wd = bmm_pkg::LCDC_INIT;
				end else begin
					ram_wd = 8'h00;
				end
				boot_we = (clr_q[14:8] == 7'd0);
				boot_wa = clr_q[7:0];
				boot_wd = 8'h00;
			end
			ST_EXEC: begin
				case (op_q)
					bmm_pkg::OP_WR_BYTE: begin
						ram_we = addr_q[15] && (addr_q != bmm_pkg::DMA_ADDR)
							&& (addr_q != bmm_pkg::JOYPAD_ADDR);
					end
					bmm_pkg::OP_WR_WORD: begin
						ram_we = addr_q[15];
					end
					bmm_pkg::OP_LD_BOOT: begin
						boot_we = (addr_q[15:8] == 8'h00);
					end
					bmm_pkg::OP_LD_CART: begin
						cart_we = (20'(coff_q) < 20'(CART_DEPTH));
					end
					default: begin
					end
				endcase
			end
			ST_JOY: begin
				// Joypad select bits 5:4 come from the written byte; the other bits keep their old value, ORed with it.
				ram_we = 1'b1;
				ram_wd = data_q[7:0] | (map_byte & bmm_pkg::JOYPAD_KEEP);
			end
			ST_WHI: begin
				ram_we = 1'b1;
				ram_wa = addr_inc[14:0];
				ram_wd = zero_data ? 8'h00 : data_q[15:8];
			end
			ST_DMA_WR: begin
				ram_we = 1'b1;
				ram_wa = {bmm_pkg::OAM_PAGE, 8'(dma_cnt_q)};
				ram_wd = map_byte;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			work_ram[ram_wa] <= ram_wd;
		end
		ram_rd_q <= work_ram[rd_addr[14:0]];
	end

	always_ff @(posedge clk) begin
		if (boot_we) begin
			boot_rom[boot_wa] <= boot_wd;
		end
		boot_rd_q <= boot_rom[rd_addr[7:0]];
	end

	always_ff @(posedge clk) begin
		if (cart_we) begin
			cart_rom[cart_wa] <= data_q[7:0];
		end
		cart_rd_q <= cart_rom[cart_ra];
	end

	// ---------------------------------------------------------------------
	// Sequencer. One request at a time walks through the states below; the
	// result waits in read_data_q until the consumer takes it.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			op_q          <= bmm_pkg::OP_RD_BYTE;
			addr_q        <= 16'd0;
			data_q        <= 16'd0;
			coff_q        <= 19'd0;
			result_q      <= 16'd0;
			read_data_q   <= 16'd0;
			out_valid_q   <= 1'b0;
			bank_q        <= 5'd1;
			boot_mapped_q <= 1'b1;
			dma_cnt_q     <= '0;
			clr_q         <= 15'd0;
			src_q         <= SRC_BOOT;
		end else begin
			src_q <= src_d;
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 15'd1;
					if (clr_q == 15'h7FFF) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q     <= bmm_pkg::op_t'(operation);
						addr_q   <= address;
						data_q   <= write_data;
						coff_q   <= cart_offset;
						result_q <= 16'd0;
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (op_q)
						bmm_pkg::OP_RD_BYTE, bmm_pkg::OP_RD_WORD: begin
							state_q <= ST_RD0;
						end
						bmm_pkg::OP_WR_BYTE, bmm_pkg::OP_WR_WORD: begin
							if (!addr_q[15]) begin
								// Bank select lives at 0x2000-0x3FFF; zero selects one.
								if (addr_q[15:13] == 3'b001) begin
									bank_q <= (data_q[4:0] == 5'd0) ? 5'd1
										: (data_q[4:0] & bmm_pkg::BANK_MASK_W);
								end
								state_q <= ST_DONE;
							end else if (op_q == bmm_pkg::OP_WR_BYTE) begin
								if (addr_q == bmm_pkg::DMA_ADDR) begin
									dma_cnt_q <= '0;
									state_q   <= ST_DMA_RD;
								end else if (addr_q == bmm_pkg::JOYPAD_ADDR) begin
									state_q <= ST_JOY;
								end else begin
									state_q <= ST_DONE;
								end
							end else if (addr_q != bmm_pkg::LAST_ADDR) begin
								state_q <= ST_WHI;
							end else begin
								state_q <= ST_DONE;
							end
						end
						bmm_pkg::OP_UNMAP: begin
							boot_mapped_q <= 1'b0;
							state_q       <= ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_RD0: begin
					result_q[7:0] <= map_byte;
					state_q       <= (op_q == bmm_pkg::OP_RD_WORD) ? ST_RD1 : ST_DONE;
				end
				ST_RD1: begin
					result_q[15:8] <= map_byte;
					state_q        <= ST_DONE;
				end
				ST_JOY, ST_WHI: begin
					state_q <= ST_DONE;
				end
				ST_DMA_RD: begin
					state_q <= ST_DMA_WR;
				end
				ST_DMA_WR: begin
					if (dma_cnt_q == DMA_LAST) begin
						state_q <= ST_DONE;
					end else begin
						dma_cnt_q <= dma_cnt_q + CNT_W'(1);
						state_q   <= ST_DMA_RD;
					end
				end
				ST_DONE: begin
					if (result_load) begin
						read_data_q <= result_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	logic in_accept;
	logic dma_busy;
	logic done_held;
	assign in_accept = in_valid && !in_stall;
	assign dma_busy  = (state_q == ST_DMA_RD) || (state_q == ST_DMA_WR);
	assign done_held = (state_q == ST_DONE) && out_valid_q && out_stall;

	// An accepted request always holds off the next one: in_stall is high in the cycle after acceptance.
	`ASSERT_NEXT(a_accept_stalls, clk, arst_n, in_accept, in_stall, "accept without stall")
	// No result may appear during the clearing pass.
	`ASSERT_SAME(a_clear_quiet, clk, arst_n, state_q == ST_CLEAR, !out_valid_q, "early result")
	// The DMA counter never runs past the last byte of the copy.
	`ASSERT_SAME(a_dma_bound, clk, arst_n, dma_busy, dma_cnt_q <= DMA_LAST, "DMA count range")
	// A finished request waits while the previous result is still held.
	`ASSERT_NEXT(a_done_waits, clk, arst_n, done_held, state_q == ST_DONE, "result overwritten")

endmodule
